FILE: sv/arms_pkg.sv
package arms_pkg;

	// Field widths used by the request interface and the block
	localparam int unsigned OP_W    = 1;
	localparam int unsigned IDX_W   = 10;
	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned COUNT_W = 11;

	// Request operation codes
	localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 1'b1;

	// Search sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_CHECK,
		ST_RESULT
	} arms_state_t;

endpackage

FILE: sv/arms_if.sv
// Request channel: table writes and address lookups
interface arms_req_if import arms_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [IDX_W-1:0]  entry_index;
	logic [ADDR_W-1:0] range_start;
	logic [ADDR_W-1:0] range_end;
	logic [ADDR_W-1:0] ip_address;

	modport source (
		output valid, op, entry_index, range_start, range_end, ip_address,
		input  ready
	);
	modport sink (
		input  valid, op, entry_index, range_start, range_end, ip_address,
		output ready
	);
endinterface

// Response channel: one membership flag per lookup
interface arms_rsp_if;
	logic valid;
	logic ready;
	logic in_range;

	modport source (
		output valid, in_range,
		input  ready
	);
	modport sink (
		input  valid, in_range,
		output ready
	);
endinterface

FILE: sv/address_range_membership_search.sv
// Address range membership search.
//
// The req channel carries two kinds of request. A write (op = OP_WRITE) stores
// range_start and range_end at entry_index; it is taken while the block is idle and gives
// no response. A lookup (op = OP_LOOKUP) binary-searches the first entry_count
// entries for the greatest start not above ip_address and returns one rsp
// response whose in_range flag says whether ip_address is at or below that
// entry's end. Entries must be sorted by start and written before lookup.
// cfg_we / cfg_wdata set entry_count; write it only while the block is idle.
//
// A lookup holds req.ready low while it runs: k halving steps in ST_SEARCH
// (each one table read and one compare in the shared unit, k <= floor(log2(count)) + 1),
// the end compare in ST_CHECK and the load of the output register in ST_RESULT.
// A lookup whose address lies below every start skips ST_CHECK, and one on an
// empty table goes straight to ST_RESULT; rsp.valid and req.ready rise together
// once the output register is loaded.
// The response sits in an output register: a stalled receiver does not block
// new requests, and a finished lookup waits in ST_RESULT until that register
// frees. Reset clears the sequencer, the output valid and entry_count; the
// table memory is not cleared and needs no clearing pass.
module address_range_membership_search import arms_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	arms_req_if.sink           req,
	arms_rsp_if.source         rsp
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	// Table memories
	logic [ADDR_W-1:0] start_mem [TABLE_DEPTH];
	logic [ADDR_W-1:0] end_mem   [TABLE_DEPTH];
	logic [ADDR_W-1:0] start_rd_q;
	logic [ADDR_W-1:0] end_rd_q;

	arms_state_t       state_q, state_nx;
	logic [COUNT_W-1:0] entry_count_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CW-1:0]     lo_q, hi_q;
	logic [AW-1:0]     mid_q;
	logic              res_q;
	logic              out_valid_q;
	logic              in_range_q;

	logic [CW-1:0]     eff_count;
	logic [CW-1:0]     lo_nx, hi_nx;
	logic [CW:0]       sum_nx;
	logic [AW-1:0]     mid_nx;
	logic              start_le;
	logic              step_more;
	logic              req_fire;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              load_out;

	// Clamp the entry count to the table depth
	always_comb begin
		if (32'(entry_count_q) > 32'(TABLE_DEPTH)) begin
			eff_count = CW'(TABLE_DEPTH);
		end else begin
			eff_count = CW'(entry_count_q);
		end
	end

	// Shared compare unit: one halving step of the search
	always_comb begin
		start_le  = (start_rd_q <= addr_q);
		lo_nx     = start_le ? (CW'(mid_q) + CW'(1)) : lo_q;
		hi_nx     = start_le ? hi_q : CW'(mid_q);
		sum_nx    = {1'b0, lo_nx} + {1'b0, hi_nx};
		mid_nx    = AW'(sum_nx >> 1);
		step_more = (lo_nx < hi_nx);
	end

	assign req_fire = req.valid && req.ready;
	assign wr_addr  = AW'(req.entry_index);

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire && req.op == OP_LOOKUP) begin
					state_nx = (eff_count == '0) ? ST_RESULT : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (!step_more) begin
					state_nx = (lo_nx == '0) ? ST_RESULT : ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_nx = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || rsp.ready) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, memory ports, output load
	always_comb begin
		req.ready = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = mid_nx;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				wr_en     = req.valid && req.op == OP_WRITE &&
				            (32'(req.entry_index) < 32'(TABLE_DEPTH));
				rd_en     = req.valid && req.op == OP_LOOKUP && eff_count != '0;
				rd_addr   = AW'(eff_count >> 1);
			end
			ST_SEARCH: begin
				rd_en   = 1'b1;
				rd_addr = step_more ? mid_nx : AW'(lo_nx - CW'(1));
			end
			ST_CHECK: begin
			end
			ST_RESULT: begin
				load_out = !out_valid_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	// Write one table entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_mem[wr_addr] <= req.range_start;
			end_mem[wr_addr]   <= req.range_end;
		end
	end

	// Registered table read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			start_rd_q <= start_mem[rd_addr];
			end_rd_q   <= end_mem[rd_addr];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				entry_count_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Search bounds, address and result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_fire && req.op == OP_LOOKUP) begin
					addr_q <= req.ip_address;
					lo_q   <= '0;
					hi_q   <= eff_count;
					mid_q  <= AW'(eff_count >> 1);
					res_q  <= 1'b0;
				end
			end
			ST_SEARCH: begin
				lo_q  <= lo_nx;
				hi_q  <= hi_nx;
				mid_q <= mid_nx;
				res_q <= 1'b0;
			end
			ST_CHECK: begin
				res_q <= (addr_q <= end_rd_q);
			end
			default: begin
			end
		endcase
		if (load_out) begin
			in_range_q <= res_q;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.in_range = in_range_q;

	// A search step always has a non-empty interval
	a_search_interval: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> lo_q < hi_q)
		else $error("search interval empty");

	// The probed entry lies inside the interval
	a_mid_in_interval: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> (CW'(mid_q) >= lo_q && CW'(mid_q) < hi_q))
		else $error("probe outside search interval");

	// No request is taken while a lookup is running
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !req.ready)
		else $error("request taken during lookup");

	// The end check only follows a search step
	a_check_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> $past(state_q) == ST_SEARCH)
		else $error("end check without search");

endmodule
